@@ sv/modular_exponentiation_core_defines.svh @@
// assertion macros shared by the modular exponentiation rtl
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MEXP_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("mexp assertion failed: same-cycle implication");

// next-cycle implication, sampled on clk, off while arst_n is low
`define MEXP_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("mexp assertion failed: next-cycle implication");

`endif

@@ sv/mexp_pkg.sv @@
package mexp_pkg;

	// default sizes and fixed field widths
	localparam int EXP_WIDTH_DEF = 64;
	localparam int MOD_WIDTH_DEF = 32;
	localparam int BASE_W        = 64;
	localparam int EXPF_W        = 64;
	localparam int RES_W         = 32;
	localparam int CFG_W         = 32;
	localparam int MOD_RESET     = 2;

	// microprogram step addresses
	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_WAIT  = 4'd0;
	localparam step_t ST_CHECK = 4'd1;
	localparam step_t ST_RBASE = 4'd2;
	localparam step_t ST_WBASE = 4'd3;
	localparam step_t ST_BIT   = 4'd4;
	localparam step_t ST_MUL   = 4'd5;
	localparam step_t ST_WMUL  = 4'd6;
	localparam step_t ST_SQR   = 4'd7;
	localparam step_t ST_WSQR  = 4'd8;
	localparam step_t ST_LOOP  = 4'd9;
	localparam step_t ST_EMIT  = 4'd10;
	localparam step_t ST_ZERO  = 4'd11;

	// datapath actions
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_RED_BASE,
		OP_SET_PW,
		OP_MUL_ACC,
		OP_SET_ACC,
		OP_SQR_PW,
		OP_NEXT_BIT,
		OP_EMIT,
		OP_CLR_ACC
	} dp_op_t;

	// sequencing conditions
	typedef enum logic [2:0] {
		CD_SEQ,
		CD_JUMP,
		CD_WAIT_IN,
		CD_WAIT_DONE,
		CD_WAIT_OUT,
		CD_IF_MSMALL,
		CD_IF_BIT_CLR,
		CD_IF_MORE
	} cond_t;

	typedef struct packed {
		dp_op_t op;
		cond_t  cond;
		step_t  target;
	} uop_t;

	// status seen by the sequencer
	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic unit_done;
		logic m_small;
		logic e_bit;
		logic more;
	} seq_stat_t;

	// control from the sequencer to the datapath
	typedef struct packed {
		dp_op_t op;
		logic   fire;
		logic   in_ready;
	} seq_ctl_t;

	// requests to the modular reduction unit
	typedef struct packed {
		logic start_mul;
		logic start_red;
	} unit_req_t;

	typedef enum logic [1:0] {
		RD_IDLE,
		RD_PROD,
		RD_SHIFT
	} red_state_t;

	// control store: right-to-left square and multiply
	function automatic uop_t uop_rom(input step_t s);
		uop_t u;
		case (s)
			ST_WAIT:  u = '{OP_LOAD,     CD_WAIT_IN,    ST_CHECK};
			ST_CHECK: u = '{OP_NOP,      CD_IF_MSMALL,  ST_ZERO};
			ST_RBASE: u = '{OP_RED_BASE, CD_SEQ,        ST_WAIT};
			ST_WBASE: u = '{OP_SET_PW,   CD_WAIT_DONE,  ST_BIT};
			ST_BIT:   u = '{OP_NOP,      CD_IF_BIT_CLR, ST_SQR};
			ST_MUL:   u = '{OP_MUL_ACC,  CD_SEQ,        ST_WAIT};
			ST_WMUL:  u = '{OP_SET_ACC,  CD_WAIT_DONE,  ST_SQR};
			ST_SQR:   u = '{OP_SQR_PW,   CD_SEQ,        ST_WAIT};
			ST_WSQR:  u = '{OP_NEXT_BIT, CD_WAIT_DONE,  ST_LOOP};
			ST_LOOP:  u = '{OP_NOP,      CD_IF_MORE,    ST_BIT};
			ST_EMIT:  u = '{OP_EMIT,     CD_WAIT_OUT,   ST_WAIT};
			ST_ZERO:  u = '{OP_CLR_ACC,  CD_JUMP,       ST_EMIT};
			default:  u = '{OP_NOP,      CD_JUMP,       ST_WAIT};
		endcase
		return u;
	endfunction

endpackage

@@ sv/mexp_in_if.sv @@
interface mexp_in_if;
	logic                         valid;
	logic                         ready;
	logic [mexp_pkg::BASE_W-1:0]  base_value;
	logic [mexp_pkg::EXPF_W-1:0]  exponent_value;

	modport source (output valid, output base_value, output exponent_value, input ready);
	modport sink (input valid, input base_value, input exponent_value, output ready);
endinterface

@@ sv/mexp_out_if.sv @@
interface mexp_out_if;
	logic                        valid;
	logic                        ready;
	logic [mexp_pkg::RES_W-1:0]  power_result;

	modport source (output valid, output power_result, input ready);
	modport sink (input valid, input power_result, output ready);
endinterface

@@ sv/mexp_modred.sv @@
`include "modular_exponentiation_core_defines.svh"

module mexp_modred #(
	parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mexp_pkg::unit_req_t         req,
	input  logic [MOD_WIDTH-1:0]        opa,
	input  logic [MOD_WIDTH-1:0]        opb,
	input  logic [MOD_WIDTH-1:0]        m,
	input  logic [mexp_pkg::BASE_W-1:0] base,
	output logic [MOD_WIDTH-1:0]        rem,
	output logic                        done
);

	localparam int BW    = mexp_pkg::BASE_W;
	localparam int CNT_W = $clog2(BW + 1);

	mexp_pkg::red_state_t state_q, state_d;
	logic [CNT_W-1:0]       cnt_q;
	logic                   done_q;
	logic [2*MOD_WIDTH-1:0] prod_full;
	logic [2*MOD_WIDTH-1:0] prod_q;
	logic [MOD_WIDTH-1:0]   r_q;
	logic [BW-1:0]          sh_q;
	logic [MOD_WIDTH:0]     rs;
	logic [MOD_WIDTH+1:0]   diff;
	logic [MOD_WIDTH-1:0]   r_red;

	// one multiplier, registered before the reduction
	assign prod_full = (2*MOD_WIDTH)'(opa) * (2*MOD_WIDTH)'(opb);

	// one restoring step: shift in a bit, subtract the modulus if it fits
	assign rs    = {r_q, sh_q[BW-1]};
	assign diff  = {1'b0, rs} - {2'b00, m};
	assign r_red = diff[MOD_WIDTH+1] ? rs[MOD_WIDTH-1:0] : diff[MOD_WIDTH-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mexp_pkg::RD_IDLE: begin
				if (req.start_mul) begin
					state_d = mexp_pkg::RD_PROD;
				end else if (req.start_red) begin
					state_d = mexp_pkg::RD_SHIFT;
				end
			end
			mexp_pkg::RD_PROD: begin
				state_d = mexp_pkg::RD_SHIFT;
			end
			mexp_pkg::RD_SHIFT: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = mexp_pkg::RD_IDLE;
				end
			end
			default: begin
				state_d = mexp_pkg::RD_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mexp_pkg::RD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == mexp_pkg::RD_SHIFT) && (cnt_q == CNT_W'(1));
			case (state_q)
				mexp_pkg::RD_IDLE: begin
					if (req.start_red && !req.start_mul) begin
						cnt_q <= CNT_W'(BW);
					end
				end
				mexp_pkg::RD_PROD: begin
					cnt_q <= CNT_W'(MOD_WIDTH);
				end
				mexp_pkg::RD_SHIFT: begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	// operand and remainder registers
	always_ff @(posedge clk) begin
		case (state_q)
			mexp_pkg::RD_IDLE: begin
				if (req.start_mul) begin
					prod_q <= prod_full;
				end else if (req.start_red) begin
					r_q  <= '0;
					sh_q <= base;
				end
			end
			mexp_pkg::RD_PROD: begin
				// high half is already below the modulus
				r_q  <= prod_q[2*MOD_WIDTH-1:MOD_WIDTH];
				sh_q <= {prod_q[MOD_WIDTH-1:0], {(BW-MOD_WIDTH){1'b0}}};
			end
			mexp_pkg::RD_SHIFT: begin
				r_q  <= r_red;
				sh_q <= {sh_q[BW-2:0], 1'b0};
			end
			default: begin
				r_q <= r_q;
			end
		endcase
	end

	assign rem  = r_q;
	assign done = done_q;

	`MEXP_ASSERT_IMPL(a_start_when_idle, req.start_mul || req.start_red, state_q == mexp_pkg::RD_IDLE)
	`MEXP_ASSERT_NEXT(a_done_pulse, done_q, !done_q)

endmodule

@@ sv/mexp_seq.sv @@
module mexp_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  mexp_pkg::seq_stat_t stat,
	output mexp_pkg::seq_ctl_t  ctl
);

	mexp_pkg::step_t step_q, step_d;
	mexp_pkg::uop_t  uop;
	mexp_pkg::step_t step_inc;
	logic            fire;

	assign uop      = mexp_pkg::uop_rom(step_q);
	assign step_inc = step_q + mexp_pkg::step_t'(1);

	// condition evaluation and next step
	always_comb begin
		fire   = 1'b1;
		step_d = step_inc;
		case (uop.cond)
			mexp_pkg::CD_SEQ: begin
				step_d = step_inc;
			end
			mexp_pkg::CD_JUMP: begin
				step_d = uop.target;
			end
			mexp_pkg::CD_WAIT_IN: begin
				fire   = stat.in_valid;
				step_d = fire ? uop.target : step_q;
			end
			mexp_pkg::CD_WAIT_DONE: begin
				fire   = stat.unit_done;
				step_d = fire ? uop.target : step_q;
			end
			mexp_pkg::CD_WAIT_OUT: begin
				fire   = stat.out_free;
				step_d = fire ? uop.target : step_q;
			end
			mexp_pkg::CD_IF_MSMALL: begin
				step_d = stat.m_small ? uop.target : step_inc;
			end
			mexp_pkg::CD_IF_BIT_CLR: begin
				step_d = !stat.e_bit ? uop.target : step_inc;
			end
			mexp_pkg::CD_IF_MORE: begin
				step_d = stat.more ? uop.target : step_inc;
			end
			default: begin
				fire   = 1'b0;
				step_d = mexp_pkg::ST_WAIT;
			end
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mexp_pkg::ST_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	assign ctl.op       = uop.op;
	assign ctl.fire     = fire;
	assign ctl.in_ready = (uop.cond == mexp_pkg::CD_WAIT_IN);

endmodule

@@ sv/modular_exponentiation_core.sv @@
// channel    | dir | fields                        | handshake
// operands   | in  | base_value, exponent_value    | valid/ready
// results    | out | power_result                  | valid/ready
// modulus_we | in  | modulus_data                  | write enable, no stall
//
// one item in flight; the base reduction and every multiply and square run
//   through the shared reduction unit, one restoring step a cycle.
// a modulus below two gives a result of zero.
// reset leaves the modulus at two and no result pending.
// the next item is taken while a result still waits in the output register;
// a full output register stalls the sequencer at its final step.
`include "modular_exponentiation_core_defines.svh"

module modular_exponentiation_core #(
	parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF,
	parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       modulus_we,
	input  logic [mexp_pkg::CFG_W-1:0] modulus_data,
	mexp_in_if.sink                    operands,
	mexp_out_if.source                 results
);

	localparam int BC_W = $clog2(EXP_WIDTH + 1);

	mexp_pkg::seq_stat_t stat;
	mexp_pkg::seq_ctl_t  ctl;
	mexp_pkg::unit_req_t req;

	logic [MOD_WIDTH-1:0]        mod_q;
	logic [MOD_WIDTH-1:0]        acc_q;
	logic [MOD_WIDTH-1:0]        pw_q;
	logic [EXP_WIDTH-1:0]        e_q;
	logic [BC_W-1:0]             bits_q;
	logic [mexp_pkg::BASE_W-1:0] base_q;
	logic                        out_valid_q;
	logic [mexp_pkg::RES_W-1:0]  out_data_q;
	logic [MOD_WIDTH-1:0]        opa;
	logic [MOD_WIDTH-1:0]        rem;
	logic                        done;
	logic                        emit_fire;

	// status for the sequencer
	assign stat.in_valid  = operands.valid;
	assign stat.out_free  = !out_valid_q || results.ready;
	assign stat.unit_done = done;
	assign stat.m_small   = (mod_q[MOD_WIDTH-1:1] == '0);
	assign stat.e_bit     = e_q[0];
	assign stat.more      = (bits_q != '0);

	mexp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	// requests to the shared reduction unit
	assign req.start_red = ctl.fire && (ctl.op == mexp_pkg::OP_RED_BASE);
	assign req.start_mul = ctl.fire &&
		((ctl.op == mexp_pkg::OP_MUL_ACC) || (ctl.op == mexp_pkg::OP_SQR_PW));
	assign opa = (ctl.op == mexp_pkg::OP_SQR_PW) ? pw_q : acc_q;

	mexp_modred #(
		.MOD_WIDTH (MOD_WIDTH)
	) u_modred (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (opa),
		.opb    (pw_q),
		.m      (mod_q),
		.base   (base_q),
		.rem    (rem),
		.done   (done)
	);

	assign emit_fire = ctl.fire && (ctl.op == mexp_pkg::OP_EMIT);

	// modulus register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q       <= MOD_WIDTH'(mexp_pkg::MOD_RESET);
			out_valid_q <= 1'b0;
		end else begin
			if (modulus_we) begin
				mod_q <= modulus_data[MOD_WIDTH-1:0];
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers, driven by the current control word
	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			case (ctl.op)
				mexp_pkg::OP_LOAD: begin
					base_q <= operands.base_value;
					e_q    <= operands.exponent_value[EXP_WIDTH-1:0];
					acc_q  <= MOD_WIDTH'(1);
					bits_q <= BC_W'(EXP_WIDTH);
				end
				mexp_pkg::OP_SET_PW: begin
					pw_q <= rem;
				end
				mexp_pkg::OP_SET_ACC: begin
					acc_q <= rem;
				end
				mexp_pkg::OP_NEXT_BIT: begin
					pw_q   <= rem;
					e_q    <= e_q >> 1;
					bits_q <= bits_q - BC_W'(1);
				end
				mexp_pkg::OP_CLR_ACC: begin
					acc_q <= '0;
				end
				mexp_pkg::OP_EMIT: begin
					out_data_q <= mexp_pkg::RES_W'(acc_q);
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign operands.ready       = ctl.in_ready;
	assign results.valid        = out_valid_q;
	assign results.power_result = out_data_q;

	`MEXP_ASSERT_NEXT(a_leave_wait, operands.valid && operands.ready, !operands.ready)
	`MEXP_ASSERT_IMPL(a_emit_room, emit_fire, !out_valid_q || results.ready)

endmodule
